// ===== design/pwmsd_pkg.sv =====
// Shared types and constants for the shadow-duty PWM generator.
`default_nettype none

package pwmsd_pkg;

    localparam int CNT_W      = 20;
    localparam int FREQ_W     = 14;
    localparam int PCT_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_W      = PCT_W + CNT_W;
    localparam int DVS_W      = FREQ_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    // Reciprocal scaling for the division by DUTY_STEPS. Ten extra fraction bits keep
    // the quotient exact for any DUTY_STEPS up to 1024 over the full product range.
    localparam int RCP_SHIFT  = DIV_W + 10;
    localparam int RCP_HALF_W = (RCP_SHIFT + 1) / 2;
    localparam int RCP_W      = 2 * RCP_HALF_W;
    localparam int PROD_W     = DIV_W + RCP_HALF_W;
    localparam int SCALE_W    = PROD_W + RCP_HALF_W;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [FREQ_W-1:0] FREQ_MIN = FREQ_W'(1);
    localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(10000);
    localparam int                FREQ_RST = 1000;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RUN  = CFG_IDX_W'(1);

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_DUTY = 1'b1;

    typedef struct packed {
        logic tick;
        logic duty_capture;
        logic duty_scale;
        logic freq_start;
        logic run_write;
        logic pend_write;
        logic period_write;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== design/pwmsd_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none

module pwmsd_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pwmsd_pkg::DIV_W-1:0]   i_dividend,
    input  wire logic [pwmsd_pkg::DVS_W-1:0]   i_divisor,
    output logic                               o_busy,
    output logic [pwmsd_pkg::DIV_W-1:0]        o_quotient
);
    import pwmsd_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== design/pwmsd_ctrl.sv =====
// Sequencer for ticks, duty requests and configuration writes.
`default_nettype none

module pwmsd_ctrl (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_mode,
    output logic                                   o_in_ready,
    input  wire logic                              i_cfg_valid,
    input  wire logic [pwmsd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    output logic                                   o_cfg_ready,
    input  wire pwmsd_pkg::t_status                i_status,
    output pwmsd_pkg::t_cmd                        o_cmd
);
    import pwmsd_pkg::*;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_MUL      = 2'd1;
    localparam logic [1:0] ST_SCALE    = 2'd2;
    localparam logic [1:0] ST_DIV_FREQ = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       in_fire;
    logic       cfg_fire;

    assign o_cfg_ready = r_state == ST_IDLE;
    assign o_in_ready  = (r_state == ST_IDLE) && i_status.out_free && !i_cfg_valid;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd                = '0;
        o_cmd.tick           = in_fire && (i_in_mode == MODE_TICK);
        o_cmd.duty_capture   = in_fire && (i_in_mode == MODE_DUTY);
        o_cmd.freq_start     = cfg_fire && (i_cfg_index == CFG_FREQ);
        o_cmd.run_write      = cfg_fire && (i_cfg_index == CFG_RUN);
        o_cmd.duty_scale     = r_state == ST_MUL;
        o_cmd.pend_write     = r_state == ST_SCALE;
        o_cmd.period_write   = (r_state == ST_DIV_FREQ) && !i_status.div_busy;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.freq_start) begin
                    n_state = ST_DIV_FREQ;
                end else if (o_cmd.duty_capture) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                n_state = ST_IDLE;
            end
            ST_DIV_FREQ: begin
                if (!i_status.div_busy) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/pwmsd_dp.sv =====
// Datapath: PWM counters, shadow duty pair, period divider and output register.
`default_nettype none

module pwmsd_dp #(
    parameter int TICKS_PER_SECOND = 1000000,
    parameter int DUTY_STEPS       = 100
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire pwmsd_pkg::t_cmd                i_cmd,
    output pwmsd_pkg::t_status                  o_status,
    input  wire logic [pwmsd_pkg::PCT_W-1:0]    i_pct,
    input  wire logic [pwmsd_pkg::FREQ_W-1:0]   i_cfg_data,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_pin_level,
    output logic                                o_period_start
);
    import pwmsd_pkg::*;

    localparam int PERIOD_RST_I = TICKS_PER_SECOND / FREQ_RST;
    localparam logic [CNT_W-1:0] PERIOD_RST =
        (PERIOD_RST_I > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(PERIOD_RST_I);

    // Rounded-up reciprocal of DUTY_STEPS, split in two halves for narrow multipliers.
    localparam longint unsigned RCP_M_I =
        ((64'd1 << RCP_SHIFT) + 64'(DUTY_STEPS) - 64'd1) / 64'(DUTY_STEPS);
    localparam logic [RCP_W-1:0]      RCP_M  = RCP_W'(RCP_M_I);
    localparam logic [RCP_HALF_W-1:0] RCP_LO = RCP_M[RCP_HALF_W-1:0];
    localparam logic [RCP_HALF_W-1:0] RCP_HI = RCP_M[RCP_W-1:RCP_HALF_W];

    logic [CNT_W-1:0] r_phase;
    logic [CNT_W-1:0] r_period;
    logic [CNT_W-1:0] r_high;
    logic [CNT_W-1:0] r_low;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_pend_high;
    logic [CNT_W-1:0] r_pend_low;
    logic [CNT_W-1:0] r_pend_len;
    logic             r_pend;
    logic             r_pin;
    logic             r_run;
    logic [DIV_W-1:0] r_prod;
    logic [PROD_W-1:0] r_part_lo;
    logic [PROD_W-1:0] r_part_hi;
    logic             r_out_valid;
    logic             r_out_pin;
    logic             r_out_start;

    logic [PCT_W-1:0]  pct_c;
    logic [FREQ_W-1:0] freq_c;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic              div_busy;
    logic [DIV_W-1:0]  div_quo;
    logic [SCALE_W-1:0] scale_sum;
    logic [CNT_W-1:0]  hi_q;

    logic             at_start;
    logic             do_load;
    logic [CNT_W-1:0] eff_high;
    logic [CNT_W-1:0] eff_low;
    logic [CNT_W-1:0] eff_len;
    logic [CNT_W:0]   phase_inc;
    logic             tick_pin;

    always_comb begin
        pct_c = i_pct;
        if (32'(i_pct) > DUTY_STEPS) pct_c = PCT_W'(DUTY_STEPS);
        freq_c = i_cfg_data;
        if (i_cfg_data < FREQ_MIN) begin
            freq_c = FREQ_MIN;
        end else if (i_cfg_data > FREQ_MAX) begin
            freq_c = FREQ_MAX;
        end
    end

    assign div_start    = i_cmd.freq_start;
    assign div_dividend = DIV_W'(TICKS_PER_SECOND);
    assign div_divisor  = freq_c;

    // The high count is product times reciprocal, shifted down by RCP_SHIFT.
    assign scale_sum = {r_part_hi, {RCP_HALF_W{1'b0}}} + SCALE_W'(r_part_lo);
    assign hi_q      = scale_sum[RCP_SHIFT +: CNT_W];

    pwmsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // A waiting shadow pair takes effect on the first tick of a period.
    always_comb begin
        at_start = r_phase == '0;
        do_load  = at_start && r_pend;
        eff_high = do_load ? r_pend_high : r_high;
        eff_low  = do_load ? r_pend_low  : r_low;
        eff_len  = do_load ? r_pend_len  : r_len;
        if (eff_len == '0) eff_len = CNT_W'(1);
        phase_inc = {1'b0, r_phase} + 1'b1;
        tick_pin  = r_pin;
        if (at_start && (eff_high != '0)) tick_pin = 1'b1;
        if ((r_phase == eff_high) && (eff_low != '0)) tick_pin = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_period    <= PERIOD_RST;
            r_high      <= '0;
            r_low       <= PERIOD_RST;
            r_len       <= PERIOD_RST;
            r_pend_high <= '0;
            r_pend_low  <= '0;
            r_pend_len  <= '0;
            r_pend      <= 1'b0;
            r_pin       <= 1'b0;
            r_run       <= 1'b0;
        end else begin
            if (i_cmd.run_write) begin
                r_run <= i_cfg_data[0];
                if (!i_cfg_data[0]) r_phase <= '0;
            end
            if (i_cmd.period_write) begin
                r_period <= (div_quo > DIV_W'(CNT_MAX)) ? CNT_MAX : div_quo[CNT_W-1:0];
            end
            if (i_cmd.pend_write) begin
                r_pend_high <= hi_q;
                r_pend_low  <= r_period - hi_q;
                r_pend_len  <= r_period;
                r_pend      <= 1'b1;
            end
            if (i_cmd.tick) begin
                if (r_run) begin
                    if (do_load) begin
                        r_high <= r_pend_high;
                        r_low  <= r_pend_low;
                        r_len  <= r_pend_len;
                        r_pend <= 1'b0;
                    end
                    r_pin   <= tick_pin;
                    r_phase <= (phase_inc >= {1'b0, eff_len}) ? '0 : phase_inc[CNT_W-1:0];
                end else begin
                    r_phase <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.duty_capture) r_prod <= DIV_W'(pct_c) * DIV_W'(r_period);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.duty_scale) begin
            r_part_lo <= PROD_W'(r_prod) * PROD_W'(RCP_LO);
            r_part_hi <= PROD_W'(r_prod) * PROD_W'(RCP_HI);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.tick || i_cmd.pend_write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_out_pin   <= r_run ? tick_pin : r_pin;
            r_out_start <= r_run && at_start;
        end else if (i_cmd.pend_write) begin
            r_out_pin   <= r_pin;
            r_out_start <= 1'b0;
        end
    end

    assign o_status.div_busy = div_busy;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_pin_level       = r_out_pin;
    assign o_period_start    = r_out_start;

endmodule

`default_nettype wire

// ===== design/pwm_generator_shadow_duty_unit.sv =====
// Top level of the one-pin PWM generator with shadowed duty updates.
//
//  channel  direction  payload
//  s        in         tuser: mode; tdata: duty_percent
//  m        out        tdata: pin_level, period_start
//  cfg      in         index 0 freq_hz, index 1 run_enable
//
// With the result taken at once and no configuration write offered, one tick is
// accepted per cycle. A duty beat runs in order through the percent times period
// product, the reciprocal partial products for the division by DUTY_STEPS, and the
// shadow load. A freq_hz write runs the one-bit-per-cycle divider over all 28
// quotient bits, between the accept and the load of the period.
// Reset is synchronous and active low; there is no clearing pass.
// The input stalls while the result register is full and not being taken, while a
// configuration write is offered, and until a duty beat or freq_hz write has finished.
`default_nettype none

module pwm_generator_shadow_duty_unit #(
    parameter int TICKS_PER_SECOND = 1000000,
    parameter int DUTY_STEPS       = 100
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [7:0]                        i_s_tdata,   // [7:0] duty_percent
    input  wire logic                              i_s_tuser,   // [0] mode
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [7:0]                             o_m_tdata,   // [0] pin_level, [1] period_start
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pwmsd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pwmsd_pkg::FREQ_W-1:0]      i_cfg_data
);
    import pwmsd_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    pin_level;
    logic    period_start;

    pwmsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_in_mode   (i_s_tuser),
        .o_in_ready  (o_s_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .o_cfg_ready (o_cfg_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pwmsd_dp #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .DUTY_STEPS       (DUTY_STEPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_pct          (i_s_tdata),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_pin_level    (pin_level),
        .o_period_start (period_start)
    );

    assign o_m_tdata = {6'b0, period_start, pin_level};

endmodule

`default_nettype wire
